### rtl/psfam_pkg.sv
// ----------------------------------------------------------------------------
// psfam_pkg
// Shared types and constants for the per-source fault anomaly monitor.
// ----------------------------------------------------------------------------
package psfam_pkg;

    localparam int SRC_W       = 5;
    localparam int KIND_W      = 32;
    localparam int INFO_W      = 64;
    localparam int TIME_W      = 64;
    localparam int CNT_W       = 16;
    localparam int SEV_W       = 2;
    localparam int EVK_W       = 3;
    localparam int NUM_EV      = 5;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 168;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register reset values
    localparam logic [31:0]      RST_STORM_WINDOW = 32'd1000000;
    localparam logic [CNT_W-1:0] RST_STORM_LIMIT  = 16'd10;
    localparam logic [31:0]      RST_RAPID_LIMIT  = 32'd5000000;
    localparam logic [CNT_W-1:0] RST_REPEAT_LIMIT = 16'd5;
    localparam logic             RST_ENFORCE      = 1'b1;

    typedef enum logic [EVK_W-1:0] {
        EV_FAULT   = 3'd0,
        EV_REPEAT  = 3'd1,
        EV_STORM   = 3'd2,
        EV_ENFORCE = 3'd3,
        EV_RAPID   = 3'd4
    } ev_kind_t;

    typedef enum logic [SEV_W-1:0] {
        SEV_WARN  = 2'd1,
        SEV_ALERT = 2'd2
    } sev_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STORM_WINDOW = 3'd0,
        CFG_STORM_LIMIT  = 3'd1,
        CFG_RAPID_LIMIT  = 3'd2,
        CFG_REPEAT_LIMIT = 3'd3,
        CFG_ENFORCE      = 3'd4
    } cfg_reg_t;

    // One monitor entry per source
    typedef struct packed {
        logic [TIME_W-1:0] first_time;
        logic              armed;
        logic [KIND_W-1:0] prev_kind;
        logic [CNT_W-1:0]  run;
        logic [TIME_W-1:0] win_start;
        logic [CNT_W-1:0]  win_cnt;
    } mon_entry_t;

    localparam int ENTRY_W = $bits(mon_entry_t);

endpackage

### rtl/psfam_ram.sv
// ----------------------------------------------------------------------------
// psfam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psfam_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/per_source_fault_anomaly_monitor_core.sv
// ----------------------------------------------------------------------------
// per_source_fault_anomaly_monitor_core
// Per-source fault monitor: repeat, storm, enforce and rapid-quarantine alerts.
// ----------------------------------------------------------------------------
// Path: an input transaction is registered into the B stage, with its RAM read, at
//   the accepting edge, then updated into the output register C once C is free.
// Throughput: one input per cycle while each yields one record and m_tready is
//   high; an input with k records holds C until its last record is taken.
// Reset: control and config registers take their reset values, entry valid
//   bits clear so every source reads as a zeroed entry; no clearing pass.
// ----------------------------------------------------------------------------
module per_source_fault_anomaly_monitor_core #(
    parameter int NUM_SOURCES = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input: source_id, fault_kind, fault_info, time_now_us, source_blocked,
    //        source_quarantined (from bit 0 up), zero pad to 168 bits
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [psfam_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Output: severity, event_source, event_fault_kind, event_detail,
    //         event_time_us (from bit 0 up), zero pad to 168 bits
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [psfam_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // tuser: event_kind
    output logic [psfam_pkg::EVK_W-1:0]           m_tuser,
    output logic                                  m_tlast,
    // Register write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psfam_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psfam_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int          AW   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [8:0]  NSRC = 9'(NUM_SOURCES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]                   storm_window_reg;
    logic [psfam_pkg::CNT_W-1:0]   storm_limit_reg;
    logic [31:0]                   rapid_limit_reg;
    logic [psfam_pkg::CNT_W-1:0]   repeat_limit_reg;
    logic                          enforce_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            storm_window_reg <= psfam_pkg::RST_STORM_WINDOW;
            storm_limit_reg  <= psfam_pkg::RST_STORM_LIMIT;
            rapid_limit_reg  <= psfam_pkg::RST_RAPID_LIMIT;
            repeat_limit_reg <= psfam_pkg::RST_REPEAT_LIMIT;
            enforce_en_reg   <= psfam_pkg::RST_ENFORCE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (psfam_pkg::cfg_reg_t'(cfg_index))
                psfam_pkg::CFG_STORM_WINDOW: storm_window_reg <= cfg_wdata;
                psfam_pkg::CFG_STORM_LIMIT:  storm_limit_reg  <= cfg_wdata[15:0];
                psfam_pkg::CFG_RAPID_LIMIT:  rapid_limit_reg  <= cfg_wdata;
                psfam_pkg::CFG_REPEAT_LIMIT: repeat_limit_reg <= cfg_wdata[15:0];
                psfam_pkg::CFG_ENFORCE:      enforce_en_reg   <= cfg_wdata[0];
                default: ;  // indexes past the list are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpack and source check
    // ------------------------------------------------------------------
    logic [psfam_pkg::SRC_W-1:0]  in_src;
    logic [psfam_pkg::KIND_W-1:0] in_kind;
    logic [psfam_pkg::INFO_W-1:0] in_info;
    logic [psfam_pkg::TIME_W-1:0] in_time;
    logic                         in_blocked;
    logic                         in_quar;
    logic                         src_ok;
    logic [8:0]                   ix_wide;
    logic [AW-1:0]                rd_addr;
    logic                         s_accept;

    assign in_src     = s_tdata[4:0];
    assign in_kind    = s_tdata[36:5];
    assign in_info    = s_tdata[100:37];
    assign in_time    = s_tdata[164:101];
    assign in_blocked = s_tdata[165];
    assign in_quar    = s_tdata[166];

    // ids of 0 or above NUM_SOURCES produce nothing and touch no entry
    assign src_ok   = (in_src != '0) && ({4'b0, in_src} <= NSRC);
    assign ix_wide  = {4'b0, in_src} - 9'd1;
    assign rd_addr  = ix_wide[AW-1:0];
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Entry RAM, valid bits and write forwarding
    // ------------------------------------------------------------------
    psfam_pkg::mon_entry_t      ram_rdata;
    psfam_pkg::mon_entry_t      wr_entry;
    logic                       wr_en;
    logic [NUM_SOURCES-1:0]     ent_vld_reg;
    logic [NUM_SOURCES-1:0]     ent_vld_next;

    // B stage: item waiting on its RAM read, updated and written back here
    logic                         b_valid_reg, b_valid_next;
    logic [AW-1:0]                b_addr_reg;
    logic [psfam_pkg::SRC_W-1:0]  b_src_reg;
    logic [psfam_pkg::KIND_W-1:0] b_kind_reg;
    logic [psfam_pkg::INFO_W-1:0] b_info_reg;
    logic [psfam_pkg::TIME_W-1:0] b_time_reg;
    logic                         b_blocked_reg;
    logic                         b_quar_reg;
    logic                         b_fwd_reg;     // read raced a write to same entry
    psfam_pkg::mon_entry_t        b_fwd_data_reg;
    logic                         b_ent_vld_reg; // entry written since reset

    psfam_ram #(
        .WIDTH (psfam_pkg::ENTRY_W),
        .DEPTH (NUM_SOURCES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (b_addr_reg),
        .wdata (wr_entry),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        ent_vld_next = ent_vld_reg;
        if (wr_en) begin
            ent_vld_next[b_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
        end else begin
            ent_vld_reg <= ent_vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage C (declared here for the ready chain)
    // ------------------------------------------------------------------
    logic                         c_valid_reg, c_valid_next;
    logic [psfam_pkg::NUM_EV-1:0] c_mask_reg, c_mask_next;
    logic [psfam_pkg::SRC_W-1:0]  c_src_reg;
    logic [psfam_pkg::KIND_W-1:0] c_kind_reg;
    logic [psfam_pkg::INFO_W-1:0] c_info_reg;
    logic [psfam_pkg::TIME_W-1:0] c_time_reg;
    logic [psfam_pkg::CNT_W-1:0]  c_run_reg;
    logic [psfam_pkg::CNT_W-1:0]  c_cnt_reg;
    logic [psfam_pkg::TIME_W-1:0] c_elapsed_reg;
    logic                         m_accept;
    logic                         c_free;

    assign m_accept = m_tvalid && m_tready;
    assign c_free   = !c_valid_reg || (m_accept && m_tlast);
    assign wr_en    = b_valid_reg && c_free;       // B moves to C and writes back
    assign s_tready = !b_valid_reg || c_free;

    always_comb begin
        b_valid_next = b_valid_reg;
        if (s_accept) begin
            b_valid_next = src_ok;
        end else if (wr_en) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_addr_reg     <= rd_addr;
            b_src_reg      <= in_src;
            b_kind_reg     <= in_kind;
            b_info_reg     <= in_info;
            b_time_reg     <= in_time;
            b_blocked_reg  <= in_blocked;
            b_quar_reg     <= in_quar;
            b_fwd_reg      <= wr_en && (b_addr_reg == rd_addr);
            b_fwd_data_reg <= wr_entry;
            b_ent_vld_reg  <= ent_vld_reg[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Entry update and event decision
    // ------------------------------------------------------------------
    psfam_pkg::mon_entry_t        cur;
    logic [psfam_pkg::TIME_W-1:0] ff_time;
    logic                         same_kind;
    logic [psfam_pkg::CNT_W-1:0]  run_new;
    logic [psfam_pkg::TIME_W-1:0] win_elapsed;
    logic                         win_restart;
    logic [psfam_pkg::CNT_W-1:0]  cnt_new;
    logic [psfam_pkg::TIME_W-1:0] rapid_elapsed;
    logic                         repeat_hit;
    logic                         storm_hit;
    logic                         enforce_hit;
    logic                         rapid_hit;
    logic [psfam_pkg::NUM_EV-1:0] ev_mask;

    always_comb begin
        if (b_fwd_reg) begin
            cur = b_fwd_data_reg;
        end else if (b_ent_vld_reg) begin
            cur = ram_rdata;
        end else begin
            cur = '0;
        end

        // first-fault clock arms on the first fault after a disarm
        ff_time = cur.armed ? cur.first_time : b_time_reg;

        same_kind = (b_kind_reg == cur.prev_kind);
        if (!same_kind) begin
            run_new = 16'd1;
        end else if (cur.run == psfam_pkg::CNT_MAX) begin
            run_new = cur.run;
        end else begin
            run_new = cur.run + 16'd1;
        end
        repeat_hit = same_kind && (run_new == repeat_limit_reg);

        win_elapsed = b_time_reg - cur.win_start;
        win_restart = win_elapsed > {32'b0, storm_window_reg};
        if (win_restart) begin
            cnt_new = 16'd1;
        end else if (cur.win_cnt == psfam_pkg::CNT_MAX) begin
            cnt_new = cur.win_cnt;
        end else begin
            cnt_new = cur.win_cnt + 16'd1;
        end
        storm_hit   = !win_restart &&
                      ({1'b0, cnt_new} == ({1'b0, storm_limit_reg} + 17'd1));
        enforce_hit = storm_hit && enforce_en_reg && !b_blocked_reg;

        // an enforce request counts as quarantining the source
        rapid_elapsed = b_time_reg - ff_time;
        rapid_hit     = (b_quar_reg || enforce_hit) &&
                        (rapid_elapsed < {32'b0, rapid_limit_reg});

        ev_mask = {rapid_hit, enforce_hit, storm_hit, repeat_hit, 1'b1};

        wr_entry.first_time = rapid_hit ? '0 : ff_time;
        wr_entry.armed      = !rapid_hit;
        wr_entry.prev_kind  = b_kind_reg;
        wr_entry.run        = run_new;
        wr_entry.win_start  = win_restart ? b_time_reg : cur.win_start;
        wr_entry.win_cnt    = cnt_new;
    end

    // ------------------------------------------------------------------
    // Output stage: one record per cycle while m_tready is high, lowest pending event first
    // ------------------------------------------------------------------
    always_comb begin
        c_valid_next = c_valid_reg;
        c_mask_next  = c_mask_reg;
        if (wr_en) begin
            c_valid_next = 1'b1;
            c_mask_next  = ev_mask;
        end else if (m_accept) begin
            c_valid_next = !m_tlast;
            c_mask_next  = c_mask_reg & (c_mask_reg - 5'd1);  // drop lowest bit
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            c_mask_reg  <= '0;
        end else begin
            c_valid_reg <= c_valid_next;
            c_mask_reg  <= c_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            c_src_reg     <= b_src_reg;
            c_kind_reg    <= b_kind_reg;
            c_info_reg    <= b_info_reg;
            c_time_reg    <= b_time_reg;
            c_run_reg     <= run_new;
            c_cnt_reg     <= cnt_new;
            c_elapsed_reg <= rapid_elapsed;
        end
    end

    psfam_pkg::ev_kind_t          cur_ev;
    psfam_pkg::sev_t              cur_sev;
    logic [psfam_pkg::INFO_W-1:0] cur_detail;

    always_comb begin
        if (c_mask_reg[0]) begin
            cur_ev = psfam_pkg::EV_FAULT;
        end else if (c_mask_reg[1]) begin
            cur_ev = psfam_pkg::EV_REPEAT;
        end else if (c_mask_reg[2]) begin
            cur_ev = psfam_pkg::EV_STORM;
        end else if (c_mask_reg[3]) begin
            cur_ev = psfam_pkg::EV_ENFORCE;
        end else begin
            cur_ev = psfam_pkg::EV_RAPID;
        end

        case (cur_ev) inside
            psfam_pkg::EV_FAULT:  cur_detail = c_info_reg;
            psfam_pkg::EV_REPEAT: cur_detail = {48'b0, c_run_reg};
            psfam_pkg::EV_STORM,
            psfam_pkg::EV_ENFORCE: cur_detail = {48'b0, c_cnt_reg};
            default:              cur_detail = c_elapsed_reg;
        endcase

        cur_sev = (cur_ev == psfam_pkg::EV_FAULT) ? psfam_pkg::SEV_WARN
                                                  : psfam_pkg::SEV_ALERT;
    end

    assign m_tvalid = c_valid_reg;
    assign m_tlast  = (c_mask_reg & (c_mask_reg - 5'd1)) == '0;
    assign m_tuser  = cur_ev;
    assign m_tdata  = {1'b0, c_time_reg, cur_detail, c_kind_reg, c_src_reg, cur_sev};

endmodule

### rtl/psfam_checker.sv
// ----------------------------------------------------------------------------
// psfam_checker
// Port-level checks on the monitor's event record stream.
// ----------------------------------------------------------------------------
module psfam_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    // stalled record holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("record changed while stalled");

    // nothing pending after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("record valid after reset");

    // records of one input follow at once, in rising event order
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser > $past(m_tuser)))
        else $error("event order broken within a report");

    // records of one input share source and timestamp
    a_same: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            (m_tdata[6:2] == $past(m_tdata[6:2])) &&
            (m_tdata[166:103] == $past(m_tdata[166:103])))
        else $error("source or time changed within a report");

endmodule

bind per_source_fault_anomaly_monitor_core psfam_checker u_psfam_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
